[rtl/bchs_pkg.sv]
// Package for the burst channel horizon scheduler.
// Field widths, register codes, controller states and the command/status structs.
// No dependencies.
`default_nettype none

package bchs_pkg;

    localparam int TIME_W  = 48;
    localparam int OFF_W   = 32;
    localparam int BITS_W  = 24;
    localparam int CH_W    = 6;
    localparam int TPB_W   = 16;
    localparam int GUARD_W = 32;
    localparam int DUR_W   = BITS_W + TPB_W;
    localparam int DG_W    = DUR_W + 1;
    localparam int SUM_W   = TIME_W + 1;
    localparam int NH_W    = TIME_W + 2;

    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    localparam int NUM_CHANNELS_DEF = 8;
    localparam int NUM_CHANNELS_MAX = 64;

    localparam logic [TIME_W-1:0] TIME_MAX  = {TIME_W{1'b1}};
    localparam logic [TPB_W-1:0]  TPB_RESET = TPB_W'(1);

    // register index taken from paddr[2]
    typedef enum logic {
        REG_TPB   = 1'b0,
        REG_GUARD = 1'b1
    } t_reg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LAST,
        ST_CALC_A,
        ST_CALC_B,
        ST_CALC_C,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic scan_clr;
        logic rd_en;
        logic calc_a;
        logic calc_b;
        logic calc_c;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic scan_last;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

[rtl/bchs_in_if.sv]
// Input channel interface: burst arrival item.
// Depends on bchs_pkg.
`default_nettype none

interface bchs_in_if;
    import bchs_pkg::*;

    logic               valid;
    logic               ready;
    logic [TIME_W-1:0]  now;
    logic [OFF_W-1:0]   max_offset;
    logic [BITS_W-1:0]  burst_bits;

    modport source (output valid, now, max_offset, burst_bits, input ready);
    modport sink   (input valid, now, max_offset, burst_bits, output ready);
endinterface

`default_nettype wire

[rtl/bchs_out_if.sv]
// Output channel interface: scheduling result item.
// Depends on bchs_pkg.
`default_nettype none

interface bchs_out_if;
    import bchs_pkg::*;

    logic               valid;
    logic               ready;
    logic [CH_W-1:0]    channel;
    logic [TIME_W-1:0]  control_time;
    logic [TIME_W-1:0]  burst_start;
    logic [TIME_W-1:0]  new_horizon;

    modport source (output valid, channel, control_time, burst_start, new_horizon,
                    input ready);
    modport sink   (input valid, channel, control_time, burst_start, new_horizon,
                    output ready);
endinterface

`default_nettype wire

[rtl/bchs_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module bchs_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 8
) (
    input  wire                                  i_clk,
    input  wire                                  i_we,
    input  wire [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire [WIDTH-1:0]                      i_wdata,
    input  wire                                  i_re,
    input  wire [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

[rtl/bchs_ctrl.sv]
// Controller state machine: accept, scan horizons, compute, emit.
// Depends on bchs_pkg.
`default_nettype none

module bchs_ctrl (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_in_valid,
    output logic            o_in_ready,
    input  bchs_pkg::t_stat i_stat,
    output bchs_pkg::t_cmd  o_cmd
);
    import bchs_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (i_in_valid) n_state = ST_SCAN;
            ST_SCAN:   if (i_stat.scan_last) n_state = ST_LAST;
            ST_LAST:   n_state = ST_CALC_A;
            ST_CALC_A: n_state = ST_CALC_B;
            ST_CALC_B: n_state = ST_CALC_C;
            ST_CALC_C: n_state = ST_EMIT;
            ST_EMIT:   if (i_stat.out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready     = 1'b1;
                o_cmd.load     = i_in_valid;
                o_cmd.scan_clr = 1'b1;
            end
            ST_SCAN:   o_cmd.rd_en  = 1'b1;
            ST_LAST:   o_cmd        = '0;
            ST_CALC_A: o_cmd.calc_a = 1'b1;
            ST_CALC_B: o_cmd.calc_b = 1'b1;
            ST_CALC_C: o_cmd.calc_c = 1'b1;
            ST_EMIT:   o_cmd.emit   = i_stat.out_free;
            default:   o_cmd        = '0;
        endcase
    end

endmodule

`default_nettype wire

[rtl/bchs_dp.sv]
// Datapath: config registers, horizon store, min scan, timing arithmetic, result register.
// Depends on bchs_pkg and bchs_ram.
`default_nettype none

module bchs_dp #(
    parameter int NUM_CHANNELS = bchs_pkg::NUM_CHANNELS_DEF
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  bchs_pkg::t_cmd                 i_cmd,
    output bchs_pkg::t_stat                o_stat,
    // config
    input  wire                            i_cfg_we,
    input  wire [bchs_pkg::APB_AW-1:0]     i_cfg_addr,
    input  wire [bchs_pkg::APB_DW-1:0]     i_cfg_wdata,
    output logic [bchs_pkg::APB_DW-1:0]    o_cfg_rdata,
    // input item
    input  wire [bchs_pkg::TIME_W-1:0]     i_now,
    input  wire [bchs_pkg::OFF_W-1:0]      i_max_offset,
    input  wire [bchs_pkg::BITS_W-1:0]     i_burst_bits,
    // result item
    output logic                           o_out_valid,
    input  wire                            i_out_ready,
    output logic [bchs_pkg::CH_W-1:0]      o_channel,
    output logic [bchs_pkg::TIME_W-1:0]    o_control_time,
    output logic [bchs_pkg::TIME_W-1:0]    o_burst_start,
    output logic [bchs_pkg::TIME_W-1:0]    o_new_horizon
);
    import bchs_pkg::*;

    localparam int IDXW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    // config registers
    logic [TPB_W-1:0]   r_tpb;
    logic [GUARD_W-1:0] r_guard;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tpb   <= TPB_RESET;
            r_guard <= '0;
        end else if (i_cfg_we) begin
            if (t_reg'(i_cfg_addr[2]) == REG_TPB) begin
                r_tpb <= i_cfg_wdata[TPB_W-1:0];
            end else begin
                r_guard <= i_cfg_wdata[GUARD_W-1:0];
            end
        end
    end

    assign o_cfg_rdata = (t_reg'(i_cfg_addr[2]) == REG_TPB) ?
                         {{(APB_DW-TPB_W){1'b0}}, r_tpb} : r_guard;

    // captured item
    logic [TIME_W-1:0] r_now;
    logic [OFF_W-1:0]  r_off;
    logic [BITS_W-1:0] r_bits;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_now  <= i_now;
            r_off  <= i_max_offset;
            r_bits <= i_burst_bits;
        end
    end

    // horizon store: entries never written read as zero
    logic [IDXW-1:0]         r_idx;
    logic [NUM_CHANNELS-1:0] r_vld;
    logic                    r_cmp_en;
    logic                    r_cmp_hit;
    logic [IDXW-1:0]         r_cmp_idx;
    logic [TIME_W-1:0]       w_rdata;
    logic [TIME_W-1:0]       w_hz;
    logic [IDXW-1:0]         r_best;
    logic [TIME_W-1:0]       r_best_h;
    logic [TIME_W-1:0]       r_nh;

    bchs_ram #(
        .WIDTH (TIME_W),
        .DEPTH (NUM_CHANNELS)
    ) u_hz_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.emit),
        .i_waddr (r_best),
        .i_wdata (r_nh),
        .i_re    (i_cmd.rd_en),
        .i_raddr (r_idx),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_cmp_en <= 1'b0;
            r_idx    <= '0;
        end else begin
            r_cmp_en <= i_cmd.rd_en;
            if (i_cmd.scan_clr) begin
                r_idx <= '0;
            end else if (i_cmd.rd_en) begin
                r_idx <= r_idx + IDXW'(1);
            end
            if (i_cmd.emit) begin
                r_vld[r_best] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_idx <= r_idx;
        r_cmp_hit <= r_vld[r_idx];
    end

    assign o_stat.scan_last = (r_idx == IDXW'(NUM_CHANNELS - 1));

    assign w_hz = r_cmp_hit ? w_rdata : '0;

    // running minimum, strict less keeps the lowest index on ties
    always_ff @(posedge i_clk) begin
        if (r_cmp_en) begin
            if ((r_cmp_idx == '0) || (w_hz < r_best_h)) begin
                r_best   <= r_cmp_idx;
                r_best_h <= w_hz;
            end
        end
    end

    // timing arithmetic
    logic [SUM_W-1:0]  r_sum;
    logic [DUR_W-1:0]  r_dur;
    logic [DG_W-1:0]   r_dg;
    logic [TIME_W-1:0] r_ctl;
    logic [TIME_W-1:0] r_start;
    logic [NH_W-1:0]   w_nh;

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc_a) begin
            r_sum <= {1'b0, r_now} + SUM_W'(r_off);
            r_dur <= DUR_W'(r_bits) * DUR_W'(r_tpb);
        end
        if (i_cmd.calc_b) begin
            if ({1'b0, r_best_h} >= r_sum) begin
                r_ctl   <= r_best_h - TIME_W'(r_off);
                r_start <= r_best_h;
            end else begin
                r_ctl   <= r_now;
                r_start <= r_sum[TIME_W] ? TIME_MAX : r_sum[TIME_W-1:0];
            end
            r_dg <= {1'b0, r_dur} + DG_W'(r_guard);
        end
        if (i_cmd.calc_c) begin
            r_nh <= (|w_nh[NH_W-1:TIME_W]) ? TIME_MAX : w_nh[TIME_W-1:0];
        end
    end

    assign w_nh = NH_W'(r_start) + NH_W'(r_dg);

    // result register
    logic r_out_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_channel      <= CH_W'(r_best);
            o_control_time <= r_ctl;
            o_burst_start  <= r_start;
            o_new_horizon  <= r_nh;
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_stat.out_free = !r_out_vld || i_out_ready;

endmodule

`default_nettype wire

[rtl/burst_channel_horizon_scheduler_unit.sv]
// Top level of the burst channel horizon scheduler.
// Depends on bchs_pkg, bchs_in_if, bchs_out_if, bchs_ctrl, bchs_dp.
//
//   port     dir   handshake            carries
//   i_in     sink  valid/ready          now, max_offset, burst_bits
//   o_out    src   valid/ready          channel, control_time, burst_start, new_horizon
//   APB      slv   psel/penable/pready  ticks_per_bit @0x0, guard_time @0x4
//
// Each item passes through these steps in order: accept, one horizon
// read per channel through the single RAM read port, one drain, three arithmetic
// steps, one write/emit. Synchronous active-low reset; horizons read as zero after
// reset through per-entry valid bits. A waiting result holds the block in the emit
// step until taken; the next item is accepted once the result register is loaded.
`default_nettype none

module burst_channel_horizon_scheduler_unit #(
    parameter int NUM_CHANNELS = bchs_pkg::NUM_CHANNELS_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    bchs_in_if.sink                      i_in,
    bchs_out_if.source                   o_out,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire [bchs_pkg::APB_AW-1:0]   paddr,
    input  wire [bchs_pkg::APB_DW-1:0]   pwdata,
    output logic [bchs_pkg::APB_DW-1:0]  prdata,
    output logic                         pready
);
    import bchs_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_cfg_we;

    assign pready   = 1'b1;
    assign w_cfg_we = psel && penable && pwrite;

    bchs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    bchs_dp #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_cfg_we       (w_cfg_we),
        .i_cfg_addr     (paddr),
        .i_cfg_wdata    (pwdata),
        .o_cfg_rdata    (prdata),
        .i_now          (i_in.now),
        .i_max_offset   (i_in.max_offset),
        .i_burst_bits   (i_in.burst_bits),
        .o_out_valid    (o_out.valid),
        .i_out_ready    (o_out.ready),
        .o_channel      (o_out.channel),
        .o_control_time (o_out.control_time),
        .o_burst_start  (o_out.burst_start),
        .o_new_horizon  (o_out.new_horizon)
    );

endmodule

`default_nettype wire

[rtl/bchs_checker.sv]
// Port-level assertions for the scheduler, bound to the top level.
// Depends on bchs_pkg and burst_channel_horizon_scheduler_unit.
`default_nettype none

module bchs_checker #(
    parameter int NUM_CHANNELS = bchs_pkg::NUM_CHANNELS_DEF
) (
    input wire                          i_clk,
    input wire                          i_rst_n,
    input wire                          i_in_valid,
    input wire                          i_in_ready,
    input wire                          i_out_valid,
    input wire                          i_out_ready,
    input wire [bchs_pkg::CH_W-1:0]     i_channel,
    input wire [bchs_pkg::TIME_W-1:0]   i_control_time,
    input wire [bchs_pkg::TIME_W-1:0]   i_burst_start,
    input wire [bchs_pkg::TIME_W-1:0]   i_new_horizon
);
    import bchs_pkg::*;

    // one item in flight: no accept right after an accept
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("item accepted while previous one in flight");

    // a held result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result dropped before taken");

    // times are ordered: control packet, burst start, new horizon
    a_time_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_control_time <= i_burst_start) &&
                        (i_burst_start <= i_new_horizon))
        else $error("result times out of order");

    a_chan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_channel < CH_W'(NUM_CHANNELS)) ||
                        (NUM_CHANNELS == NUM_CHANNELS_MAX))
        else $error("channel index out of range");

endmodule

bind burst_channel_horizon_scheduler_unit bchs_checker #(
    .NUM_CHANNELS (NUM_CHANNELS)
) u_bchs_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_channel      (o_out.channel),
    .i_control_time (o_out.control_time),
    .i_burst_start  (o_out.burst_start),
    .i_new_horizon  (o_out.new_horizon)
);

`default_nettype wire
